// ===== design/spr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and tables of the sine colour palette.
// Used by every module of the block but spr_ram; depends on nothing else.

package spr_pkg;

    localparam int COUNT_BITS_DEF     = 16;
    localparam int SINE_ROM_DEPTH_DEF = 1024;

    localparam int COUNT_FIELD_W = 16;
    localparam int COLOR_W       = 8;
    localparam int MODE_W        = 3;
    localparam int NUM_CH        = 3;
    localparam int NUM_MODES     = 7;

    localparam logic [MODE_W-1:0] MODE_BLACK = 3'd0;

    // Q30 fixed point for the sine table build.
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

    // Taylor terms after the first; each is divided by a small constant
    // through multiplication by its reciprocal.
    localparam int TERM_COUNT    = 7;

    // Per-mode, per-channel frequency and phase as 32-bit fractions of a turn.
    // Row 0 belongs to mode 1; channel order is red, green, blue.
    localparam logic [31:0] COEF_FREQ [NUM_MODES][NUM_CH] = '{
        '{32'd273426110, 32'd68356528,  32'd150384361},
        '{32'd68356528,  32'd6835653,   32'd300768721},
        '{32'd68356528,  32'd615208748, 32'd478495693},
        '{32'd205069583, 32'd205069583, 32'd205069583},
        '{32'd205069583, 32'd136713055, 32'd205069583},
        '{32'd341782638, 32'd6835653,   32'd546852220},
        '{32'd683565,    32'd205069583, 32'd30076872}
    };

    localparam logic [31:0] COEF_PHASE [NUM_MODES][NUM_CH] = '{
        '{32'd1070716561, 32'd1082817614, 32'd3907816011},
        '{32'd3907816011, 32'd3248452842, 32'd2734261102},
        '{32'd0,          32'd2746362156, 32'd2141433121},
        '{32'd0,          32'd1367130551, 32'd2734261102},
        '{32'd3907816011, 32'd3417826378, 32'd2540685460},
        '{32'd0,          32'd502090686,  32'd4282866243},
        '{32'd683565276,  32'd1857120184, 32'd1173554909}
    };

    // Factorial ratio (2n)(2n+1) between successive Taylor terms.
    function automatic logic [7:0] term_divisor(input logic [2:0] n);
        logic [7:0] d;
        unique case (n)
            3'd1:    d = 8'd6;
            3'd2:    d = 8'd20;
            3'd3:    d = 8'd42;
            3'd4:    d = 8'd72;
            3'd5:    d = 8'd110;
            3'd6:    d = 8'd156;
            3'd7:    d = 8'd210;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor) for each Taylor term.
    function automatic logic [31:0] term_reciprocal(input logic [2:0] n);
        logic [31:0] m;
        unique case (n)
            3'd1:    m = 32'd715827882;
            3'd2:    m = 32'd214748364;
            3'd3:    m = 32'd102261126;
            3'd4:    m = 32'd59652323;
            3'd5:    m = 32'd39045157;
            3'd6:    m = 32'd27531841;
            3'd7:    m = 32'd20452225;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// ===== design/sine_palette_rgb.sv =====
`timescale 1ns / 1ps
// Top level of the sine colour palette: mode register, table builder and
// colour pipeline. Uses spr_pkg, spr_sine_gen and spr_color_pipe.

// Each transfer on the s_ side carries one escape iteration count and yields
// exactly one RGB transfer on the m_ side, in order. Each channel is
// floor(sin(f*count + p)*127 + 128) taken from a sine table of
// SINE_ROM_DEPTH entries, with f and p chosen per channel by palette_mode;
// mode 0 gives black. The pipeline takes one transfer per clock while
// m_tready is held high; it has six register stages (coefficient select,
// 32-bit multiply, phase add, table index, table read, output). After
// reset the sine table is computed entry by entry into RAM, during which
// s_tready stays low; palette_mode writes are taken at any time and
// should only be made while no transfer is in flight.

module sine_palette_rgb
    import spr_pkg::*;
#(
    parameter int COUNT_BITS     = COUNT_BITS_DEF,
    parameter int SINE_ROM_DEPTH = SINE_ROM_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [MODE_W-1:0] cfg_wr_data,  // palette_mode
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,      // [15:0] iteration_count
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata       // [7:0] red, [15:8] green, [23:16] blue
);

    localparam int IDX_W = $clog2(SINE_ROM_DEPTH);

    logic [MODE_W-1:0]  mode_reg;
    logic               fill_done;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [COLOR_W-1:0] wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_BLACK;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    spr_sine_gen #(
        .SINE_ROM_DEPTH (SINE_ROM_DEPTH)
    ) u_sine_gen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .fill_done (fill_done)
    );

    spr_color_pipe #(
        .COUNT_BITS     (COUNT_BITS),
        .SINE_ROM_DEPTH (SINE_ROM_DEPTH)
    ) u_color_pipe (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .palette_mode (mode_reg),
        .fill_done    (fill_done),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

// ===== design/spr_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module spr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/spr_sine_gen.sv =====
`timescale 1ns / 1ps
// Sequencer that builds the sine table after reset, one entry at a time, with a
// shared 32x32 multiplier used for the series and for reciprocal division. Uses spr_pkg.

module spr_sine_gen
    import spr_pkg::*;
#(
    parameter int SINE_ROM_DEPTH = SINE_ROM_DEPTH_DEF,
    localparam int IDX_W = $clog2(SINE_ROM_DEPTH)
) (
    input  logic               aclk,
    input  logic               aresetn,
    output logic               wr_en,
    output logic [IDX_W-1:0]   wr_addr,
    output logic [COLOR_W-1:0] wr_data,
    output logic               fill_done
);

    localparam longint unsigned TURN = 64'h1_0000_0000;
    localparam logic [31:0] STEP_Q = 32'(TURN / SINE_ROM_DEPTH);
    localparam logic [IDX_W-1:0] STEP_R = IDX_W'(TURN % SINE_ROM_DEPTH);
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(SINE_ROM_DEPTH - 1);
    localparam logic [IDX_W:0] DEPTH_W = (IDX_W + 1)'(SINE_ROM_DEPTH);
    localparam logic [2:0] LAST_TERM = 3'(TERM_COUNT);

    typedef enum logic [3:0] {
        ST_SETUP, ST_MUL_X, ST_LOAD_X, ST_MUL_X2, ST_LOAD_X2,
        ST_MUL_T, ST_RECIP, ST_BACK, ST_FIX, ST_ACC, ST_WRITE, ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic [31:0]        turn_reg, turn_next;
    logic [IDX_W-1:0]   frac_reg, frac_next;
    logic [1:0]         quad_reg, quad_next;
    logic [29:0]        r_reg, r_next;
    logic [31:0]        x2_reg, x2_next;
    logic [30:0]        term_reg, term_next;
    logic [31:0]        sum_reg, sum_next;
    logic [2:0]         n_reg, n_next;
    logic [31:0]        dq_reg, dq_next;
    logic [31:0]        quot_reg, quot_next;
    logic [63:0]        prod_reg;
    logic [31:0]        mul_a, mul_b;

    logic [30:0]        mirror;
    logic [IDX_W:0]     frac_sum;
    logic [31:0]        remain;
    logic [7:0]         divisor;
    logic [31:0]        recip;
    logic [30:0]        s_clamp;
    logic [37:0]        scaled;
    logic [37:0]        scaled_up;

    assign divisor = term_divisor(n_reg);
    assign recip   = term_reciprocal(n_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_X: begin
                mul_a = {2'b00, r_reg};
                mul_b = HALF_PI_Q30;
            end
            ST_MUL_X2: begin
                mul_a = {1'b0, term_reg};
                mul_b = {1'b0, term_reg};
            end
            ST_MUL_T: begin
                mul_a = {1'b0, term_reg};
                mul_b = x2_reg;
            end
            ST_RECIP: begin
                mul_a = prod_reg[61:30];
                mul_b = recip;
            end
            ST_BACK: begin
                mul_a = prod_reg[63:32];
                mul_b = {24'd0, divisor};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Clamp and scale to 127 * s for the table value.
    always_comb begin
        s_clamp   = (sum_reg > {1'b0, Q30_ONE}) ? Q30_ONE : sum_reg[30:0];
        scaled    = {s_clamp, 7'd0} - {7'd0, s_clamp};
        scaled_up = scaled + 38'({Q30_ONE - 31'd1});
        if (quad_reg[1]) begin
            wr_data = 8'd128 - scaled_up[37:30];
        end else begin
            wr_data = 8'd128 + scaled[37:30];
        end
    end

    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        turn_next  = turn_reg;
        frac_next  = frac_reg;
        quad_next  = quad_reg;
        r_next     = r_reg;
        x2_next    = x2_reg;
        term_next  = term_reg;
        sum_next   = sum_reg;
        n_next     = n_reg;
        dq_next    = dq_reg;
        quot_next  = quot_reg;
        mirror     = '0;
        frac_sum   = '0;
        remain     = '0;

        unique case (state_reg)
            ST_SETUP: begin
                quad_next = turn_reg[31:30];
                if (turn_reg[30]) begin
                    mirror = Q30_ONE - {1'b0, turn_reg[29:0]};
                end else begin
                    mirror = {1'b0, turn_reg[29:0]};
                end
                if (mirror == '0) begin
                    sum_next   = '0;
                    state_next = ST_WRITE;
                end else if (mirror == Q30_ONE) begin
                    sum_next   = {1'b0, Q30_ONE};
                    state_next = ST_WRITE;
                end else begin
                    r_next     = mirror[29:0];
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X: begin
                state_next = ST_LOAD_X;
            end
            ST_LOAD_X: begin
                term_next  = prod_reg[60:30];
                sum_next   = {1'b0, prod_reg[60:30]};
                state_next = ST_MUL_X2;
            end
            ST_MUL_X2: begin
                state_next = ST_LOAD_X2;
            end
            ST_LOAD_X2: begin
                x2_next    = prod_reg[61:30];
                n_next     = 3'd1;
                state_next = ST_MUL_T;
            end
            ST_MUL_T: begin
                state_next = ST_RECIP;
            end
            ST_RECIP: begin
                // The dividend stays below 2^32 for every term.
                dq_next    = prod_reg[61:30];
                state_next = ST_BACK;
            end
            ST_BACK: begin
                // The reciprocal estimate is exact or one below the quotient.
                quot_next  = prod_reg[63:32];
                state_next = ST_FIX;
            end
            ST_FIX: begin
                remain = dq_reg - prod_reg[31:0];
                if (remain >= {24'd0, divisor}) begin
                    quot_next = quot_reg + 32'd1;
                end
                state_next = ST_ACC;
            end
            ST_ACC: begin
                term_next = quot_reg[30:0];
                if (n_reg[0]) begin
                    sum_next = (sum_reg >= {1'b0, quot_reg[30:0]})
                             ? sum_reg - {1'b0, quot_reg[30:0]} : '0;
                end else begin
                    sum_next = sum_reg + {1'b0, quot_reg[30:0]};
                end
                if (n_reg == LAST_TERM) begin
                    state_next = ST_WRITE;
                end else begin
                    n_next     = n_reg + 3'd1;
                    state_next = ST_MUL_T;
                end
            end
            ST_WRITE: begin
                if (addr_reg == LAST_ADDR) begin
                    state_next = ST_DONE;
                end else begin
                    // Step the table angle by one entry, carrying the
                    // fractional remainder of 2^32 / depth.
                    addr_next = addr_reg + IDX_W'(1);
                    frac_sum  = {1'b0, frac_reg} + {1'b0, STEP_R};
                    if (frac_sum >= DEPTH_W) begin
                        frac_next = IDX_W'(frac_sum - DEPTH_W);
                        turn_next = turn_reg + STEP_Q + 32'd1;
                    end else begin
                        frac_next = frac_sum[IDX_W-1:0];
                        turn_next = turn_reg + STEP_Q;
                    end
                    state_next = ST_SETUP;
                end
            end
            ST_DONE: begin
                state_next = ST_DONE;
            end
            default: begin
                state_next = ST_SETUP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SETUP;
            addr_reg  <= '0;
            turn_reg  <= '0;
            frac_reg  <= '0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            turn_reg  <= turn_next;
            frac_reg  <= frac_next;
        end
        quad_reg <= quad_next;
        r_reg    <= r_next;
        x2_reg   <= x2_next;
        term_reg <= term_next;
        sum_reg  <= sum_next;
        n_reg    <= n_next;
        dq_reg   <= dq_next;
        quot_reg <= quot_next;
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    assign wr_en     = (state_reg == ST_WRITE);
    assign wr_addr   = addr_reg;
    assign fill_done = (state_reg == ST_DONE);

endmodule

// ===== design/spr_color_pipe.sv =====
`timescale 1ns / 1ps
// Six-stage colour pipeline: coefficient select, multiply, phase add,
// table index, sine table read, output register. Uses spr_pkg and spr_ram.

module spr_color_pipe
    import spr_pkg::*;
#(
    parameter int COUNT_BITS     = COUNT_BITS_DEF,
    parameter int SINE_ROM_DEPTH = SINE_ROM_DEPTH_DEF,
    localparam int IDX_W = $clog2(SINE_ROM_DEPTH)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [MODE_W-1:0]  palette_mode,
    input  logic               fill_done,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [COLOR_W-1:0] wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,    // [15:0] iteration_count
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata     // [7:0] red, [15:8] green, [23:16] blue
);

    localparam int CNT_W = (COUNT_BITS < COUNT_FIELD_W) ? COUNT_BITS : COUNT_FIELD_W;
    localparam int SCALE_W = 32 + IDX_W + 1;

    logic va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg;
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f;
    logic in_acc;

    logic             black_a_reg, black_b_reg, black_c_reg, black_d_reg, black_e_reg;
    logic [CNT_W-1:0] count_a_reg;
    logic [31:0]      freq_a_reg  [NUM_CH];
    logic [31:0]      phase_a_reg [NUM_CH];
    logic [31:0]      prod_b_reg  [NUM_CH];
    logic [31:0]      phase_b_reg [NUM_CH];
    logic [31:0]      angle_c_reg [NUM_CH];
    logic [IDX_W-1:0] index_d_reg [NUM_CH];
    logic [COLOR_W-1:0] ram_q     [NUM_CH];
    logic [COLOR_W-1:0] color_f_reg [NUM_CH];
    logic [SCALE_W-1:0] scaled    [NUM_CH];

    logic             in_black;
    logic [2:0]       mode_sel;

    // A stage takes new data when it is empty or its content moves on.
    assign rdy_f = !vf_reg || m_tready;
    assign rdy_e = !ve_reg || rdy_f;
    assign rdy_d = !vd_reg || rdy_e;
    assign rdy_c = !vc_reg || rdy_d;
    assign rdy_b = !vb_reg || rdy_c;
    assign rdy_a = !va_reg || rdy_b;

    assign s_tready = rdy_a && fill_done;
    assign in_acc   = s_tvalid && s_tready;

    assign in_black = (palette_mode == MODE_BLACK);
    assign mode_sel = in_black ? 3'd0 : palette_mode - 3'd1;

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            scaled[ch] = SCALE_W'(angle_c_reg[ch]) * SCALE_W'(SINE_ROM_DEPTH);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end else begin
            if (rdy_a) begin
                va_reg <= in_acc;
            end
            if (rdy_b) begin
                vb_reg <= va_reg;
            end
            if (rdy_c) begin
                vc_reg <= vb_reg;
            end
            if (rdy_d) begin
                vd_reg <= vc_reg;
            end
            if (rdy_e) begin
                ve_reg <= vd_reg;
            end
            if (rdy_f) begin
                vf_reg <= ve_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            black_a_reg <= in_black;
            count_a_reg <= s_tdata[CNT_W-1:0];
            for (int ch = 0; ch < NUM_CH; ch++) begin
                freq_a_reg[ch]  <= COEF_FREQ[mode_sel][ch];
                phase_a_reg[ch] <= COEF_PHASE[mode_sel][ch];
            end
        end
        if (rdy_b) begin
            black_b_reg <= black_a_reg;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                // Only the low 32 bits matter: the angle wraps at one turn.
                prod_b_reg[ch]  <= 32'(freq_a_reg[ch] * 32'(count_a_reg));
                phase_b_reg[ch] <= phase_a_reg[ch];
            end
        end
        if (rdy_c) begin
            black_c_reg <= black_b_reg;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                angle_c_reg[ch] <= prod_b_reg[ch] + phase_b_reg[ch];
            end
        end
        if (rdy_d) begin
            black_d_reg <= black_c_reg;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                index_d_reg[ch] <= scaled[ch][32 +: IDX_W];
            end
        end
        if (rdy_e) begin
            black_e_reg <= black_d_reg;
        end
        if (rdy_f) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                color_f_reg[ch] <= black_e_reg ? '0 : ram_q[ch];
            end
        end
    end

    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_table
        spr_ram #(
            .WIDTH (COLOR_W),
            .DEPTH (SINE_ROM_DEPTH)
        ) u_sine_ram (
            .aclk    (aclk),
            .wr_en   (wr_en),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_en   (rdy_e),
            .rd_addr (index_d_reg[ch]),
            .rd_data (ram_q[ch])
        );
    end

    assign m_tvalid = vf_reg;
    assign m_tdata  = {color_f_reg[2], color_f_reg[1], color_f_reg[0]};

endmodule

// ===== tb/sine_palette_rgb_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sine_palette_rgb: a directed table and random pixel counts
// under several palette modes, with random stalls on both streams.
// Depends on spr_pkg and the sine_palette_rgb RTL only.

module sine_palette_rgb_tb;

    localparam int LUT_DEPTH   = 1024;
    localparam int DIR_ROWS    = 21;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 135;
    localparam int STALL_LIMIT = 500000;
    localparam int TAIL_CYCLES = 12;
    localparam logic [63:0] UNIT_Q30 = 64'h4000_0000;
    localparam logic [63:0] HALF_PI  = 64'd1686629713;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } colour_t;

    typedef struct packed {
        logic [spr_pkg::MODE_W-1:0] mode;
        logic [15:0]                cnt;
        logic                       typed;
        colour_t                    want;
    } dir_row_t;

    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [spr_pkg::MODE_W-1:0] cfg_wr_data = spr_pkg::MODE_BLACK;
    logic                       s_tvalid    = 1'b0;
    logic                       s_tready;
    logic [15:0]                s_tdata     = 16'd0;
    logic                       m_tvalid;
    logic                       m_tready    = 1'b0;
    logic [23:0]                m_tdata;

    logic [7:0]                 sine_lut [LUT_DEPTH];
    colour_t                    pending_colours [$];
    logic [spr_pkg::MODE_W-1:0] palette_now = spr_pkg::MODE_BLACK;
    bit                         calm        = 1'b0;
    int                         mismatches  = 0;
    int                         colours_in  = 0;
    int                         counts_out  = 0;
    int                         mode_writes = 0;
    int                         quiet       = 0;

    sine_palette_rgb DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Table entry k: quarter-wave Taylor series in Q30, mirrored by quadrant.
    function automatic logic [7:0] sine_level(input int unsigned k);
        logic [63:0] t, r, s, x, x2, term;
        logic [1:0]  quad;
        int          n;
        t    = (64'(k) << 32) / LUT_DEPTH;
        quad = t[31:30];
        r    = t & (UNIT_Q30 - 1);
        if (quad[0])
            r = UNIT_Q30 - r;
        if (r == 0) begin
            s = 0;
        end else if (r == UNIT_Q30) begin
            s = UNIT_Q30;
        end else begin
            x    = (r * HALF_PI) >> 30;
            x2   = (x * x) >> 30;
            s    = x;
            term = x;
            for (n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    s = (s >= term) ? s - term : 64'd0;
                else
                    s = s + term;
            end
            if (s > UNIT_Q30)
                s = UNIT_Q30;
        end
        if (quad < 2)
            return 8'(128 + ((127 * s) >> 30));
        return 8'(128 - ((127 * s + UNIT_Q30 - 1) >> 30));
    endfunction

    // Frequencies and phases per mode row, packed {red, green, blue}.
    function automatic logic [95:0] freq_row(input int row);
        case (row)
            0:       return {32'd273426110, 32'd68356528,  32'd150384361};
            1:       return {32'd68356528,  32'd6835653,   32'd300768721};
            2:       return {32'd68356528,  32'd615208748, 32'd478495693};
            3:       return {32'd205069583, 32'd205069583, 32'd205069583};
            4:       return {32'd205069583, 32'd136713055, 32'd205069583};
            5:       return {32'd341782638, 32'd6835653,   32'd546852220};
            default: return {32'd683565,    32'd205069583, 32'd30076872};
        endcase
    endfunction

    function automatic logic [95:0] phase_row(input int row);
        case (row)
            0:       return {32'd1070716561, 32'd1082817614, 32'd3907816011};
            1:       return {32'd3907816011, 32'd3248452842, 32'd2734261102};
            2:       return {32'd0,          32'd2746362156, 32'd2141433121};
            3:       return {32'd0,          32'd1367130551, 32'd2734261102};
            4:       return {32'd3907816011, 32'd3417826378, 32'd2540685460};
            5:       return {32'd0,          32'd502090686,  32'd4282866243};
            default: return {32'd683565276,  32'd1857120184, 32'd1173554909};
        endcase
    endfunction

    function automatic colour_t predict_colour(input logic [spr_pkg::MODE_W-1:0] mode,
                                               input logic [15:0] cnt);
        colour_t     c;
        logic [95:0] fr, ph;
        logic [31:0] angle;
        logic [7:0]  lv [3];
        int          ch;
        c = '0;
        if (mode != spr_pkg::MODE_BLACK) begin
            fr = freq_row(int'(mode) - 1);
            ph = phase_row(int'(mode) - 1);
            for (ch = 0; ch < 3; ch++) begin
                angle  = fr[95 - 32 * ch -: 32] * {16'd0, cnt} + ph[95 - 32 * ch -: 32];
                lv[ch] = sine_lut[angle[31:22]];
            end
            c.red   = lv[0];
            c.green = lv[1];
            c.blue  = lv[2];
        end
        return c;
    endfunction

    // Directed table; black rows carry their expected colour, the rest are predicted.
    function automatic dir_row_t directed_row(input int i);
        dir_row_t d;
        d = '0;
        case (i)
            0:  d = '{spr_pkg::MODE_BLACK, 16'd0,      1'b1, '0};
            1:  d = '{spr_pkg::MODE_BLACK, 16'hFFFF,   1'b1, '0};
            2:  d = '{spr_pkg::MODE_BLACK, 16'hAAAA,   1'b1, '0};
            3:  d = '{3'd1, 16'd0,      1'b0, '0};
            4:  d = '{3'd1, 16'hFFFF,   1'b0, '0};
            5:  d = '{3'd1, 16'd1,      1'b0, '0};
            6:  d = '{3'd2, 16'd0,      1'b0, '0};
            7:  d = '{3'd2, 16'hFFFF,   1'b0, '0};
            8:  d = '{3'd3, 16'd0,      1'b0, '0};
            9:  d = '{3'd3, 16'hFFFF,   1'b0, '0};
            10: d = '{3'd3, 16'h5555,   1'b0, '0};
            11: d = '{3'd4, 16'd0,      1'b0, '0};
            12: d = '{3'd4, 16'hFFFF,   1'b0, '0};
            13: d = '{3'd5, 16'd0,      1'b0, '0};
            14: d = '{3'd5, 16'hFFFF,   1'b0, '0};
            15: d = '{3'd6, 16'd0,      1'b0, '0};
            16: d = '{3'd6, 16'hFFFF,   1'b0, '0};
            17: d = '{3'd7, 16'd0,      1'b0, '0};
            18: d = '{3'd7, 16'hFFFF,   1'b0, '0};
            19: d = '{3'd7, 16'h8000,   1'b0, '0};
            default: d = '{spr_pkg::MODE_BLACK, 16'h1234, 1'b1, '0};
        endcase
        return d;
    endfunction

    task automatic drop_valid();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain_colours();
        drop_valid();
        while (pending_colours.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_palette(input logic [spr_pkg::MODE_W-1:0] mode);
        drain_colours();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        palette_now = mode;
        mode_writes++;
    endtask

    // One count transfer; the expected colour is queued at the accepting edge.
    task automatic send_count(input logic [15:0] cnt, input colour_t want);
        int gap;
        if (!calm && $urandom_range(99) < 33) begin
            gap = $urandom_range(1, 4);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= cnt;
        do @(posedge aclk); while (!s_tready);
        pending_colours.push_back(want);
        counts_out++;
    endtask

    function automatic logic [15:0] random_count();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return 16'($urandom);
        if (pick < 75)
            return 16'($urandom_range(0, 255));
        if (pick < 85) begin
            case ($urandom_range(3))
                0:       return 16'd0;
                1:       return 16'hFFFF;
                2:       return 16'd1;
                default: return 16'hFFFE;
            endcase
        end
        return 16'($urandom_range(0, 4095));
    endfunction

    always @(negedge aclk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 33);

    always @(posedge aclk) begin
        colour_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = colour_t'(m_tdata);
            colours_in++;
            if (pending_colours.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected colour transfer r=%0d g=%0d b=%0d",
                             got.red, got.green, got.blue);
            end else begin
                want = pending_colours.pop_front();
                if (got.red !== want.red || got.green !== want.green
                        || got.blue !== want.blue) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Colour mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                end
            end
        end
    end

    // The table build after reset keeps s_tready low.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        dir_row_t                   row;
        colour_t                    want;
        logic [15:0]                cnt;
        logic [spr_pkg::MODE_W-1:0] mode;
        int                         i, p;
        for (i = 0; i < LUT_DEPTH; i++)
            sine_lut[i] = sine_level(i);

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            row = directed_row(i);
            if (row.mode != palette_now)
                set_palette(row.mode);
            want = row.typed ? row.want : predict_colour(palette_now, row.cnt);
            send_count(row.cnt, want);
        end

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0:       mode = 3'd7;
                1:       mode = 3'd1;
                7:       mode = spr_pkg::MODE_BLACK;
                default: mode = 3'($urandom_range(0, 7));
            endcase
            set_palette(mode);
            calm = (p == 2);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                // Hold the sender back once until the pipeline has emptied.
                if (p == 4 && i == PHASE_ITEMS / 2)
                    drain_colours();
                cnt = random_count();
                send_count(cnt, predict_colour(palette_now, cnt));
            end
            calm = 1'b0;
        end

        drain_colours();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d pixel counts and checked %0d colours across %0d palette writes,",
                 counts_out, colours_in, mode_writes);
        $display("covering black mode, modes 1 to 7 and count extremes under random stalls.");
        if (mismatches == 0 && pending_colours.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d colours outstanding", mismatches,
                     pending_colours.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sine_palette_rgb.f =====
design/spr_pkg.sv
design/spr_ram.sv
design/spr_sine_gen.sv
design/spr_color_pipe.sv
design/sine_palette_rgb.sv
tb/sine_palette_rgb_tb.sv
